[sv/planar_arm_forward_kinematics_unit_assert.svh]
// Assertion macros for the planar arm forward kinematics unit.
// Depends on clk_i and rst_ni being present in the asserting module.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PAFK_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pafk assertion failed");
`define PAFK_ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("pafk assertion failed");
`else
`define PAFK_ASSERT(label, prop)
`define PAFK_ASSERT_NEVER(label, prop)
`endif
`endif

[sv/pafk_pkg.sv]
// Package for the planar arm forward kinematics unit.
// Holds sizes, register indexes and sine polynomial constants; no dependencies.
`default_nettype none
package pafk_pkg;
  localparam int MaxLinksDef  = 4;
  localparam int AngleBitsDef = 16;
  localparam int Carried      = 4;
  localparam int PosW         = 24;
  localparam int LenW         = 16;
  localparam int InAngW       = 16;
  localparam int WhichW       = 3;
  localparam int NumLinksW    = 3;
  localparam int CfgIdxW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_X   = 3'd0,
    REG_BASE_Y   = 3'd1,
    REG_NUM      = 3'd2,
    REG_LEN0     = 3'd3,
    REG_LEN1     = 3'd4,
    REG_LEN2     = 3'd5,
    REG_LEN3     = 3'd6,
    REG_UNUSED   = 3'd7
  } cfg_reg_e;

  localparam logic [30:0] TrigA  = 31'd1686629713;
  localparam logic [29:0] TrigB  = 30'd688904867;
  localparam logic [26:0] TrigC  = 27'd76016977;
  localparam logic [30:0] Q30One = 31'd1073741824;

  localparam logic [LenW-1:0] LenReset = 16'd4096;
  localparam logic [NumLinksW-1:0] NumReset = 3'd2;
endpackage
`default_nettype wire

[sv/planar_arm_forward_kinematics_unit.sv]
// Planar arm forward kinematics unit: eight-stage pipeline, one pose query a beat.
// Depends on pafk_pkg and planar_arm_forward_kinematics_unit_assert.svh.
`default_nettype none
`include "planar_arm_forward_kinematics_unit_assert.svh"
// Takes one beat of joint angles plus a joint index per cycle while the output
// is not stalled, and returns that joint's x,y position. The pipeline is made of
// the entry register that holds the summed and quadrant-folded angles, the four
// dependent polynomial multiplies of the sine/cosine lanes, each followed by a
// register, plus the link-scaling multiply, the sum and the saturating output
// register. Every link has its own cosine and sine lane, so all links are
// evaluated in parallel. The pipeline stalls as a whole when the output beat is
// not taken; in_ready_o falls only then. Configuration is read live, so write it
// only while the unit is empty.
module planar_arm_forward_kinematics_unit #(
  parameter int MAX_LINKS  = pafk_pkg::MaxLinksDef,
  parameter int ANGLE_BITS = pafk_pkg::AngleBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pafk_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [pafk_pkg::PosW-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [pafk_pkg::InAngW-1:0]     angle_joint0_i,
  input  wire logic [pafk_pkg::InAngW-1:0]     angle_joint1_i,
  input  wire logic [pafk_pkg::InAngW-1:0]     angle_joint2_i,
  input  wire logic [pafk_pkg::InAngW-1:0]     angle_joint3_i,
  input  wire logic [pafk_pkg::WhichW-1:0]     which_joint_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [pafk_pkg::PosW-1:0]     pos_x_o,
  output logic signed [pafk_pkg::PosW-1:0]     pos_y_o,
  output logic                                 index_error_o
);
  import pafk_pkg::*;

  localparam int NL    = 2 * MAX_LINKS;            // lane 2k: cosine, 2k+1: sine
  localparam int NW    = $clog2(MAX_LINKS + 1);
  localparam int SUM_W = PosW + 2 + $clog2(MAX_LINKS + 1);
  localparam int NS    = 8;

  // configuration registers
  logic signed [PosW-1:0]      base_x_q, base_y_q;
  logic [NumLinksW-1:0]        num_links_q;
  logic [LenW-1:0]             len_q [Carried];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q    <= '0;
      base_y_q    <= '0;
      num_links_q <= NumReset;
      for (int k = 0; k < Carried; k++) len_q[k] <= LenReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_X: base_x_q    <= cfg_data_i;
        REG_BASE_Y: base_y_q    <= cfg_data_i;
        REG_NUM:    num_links_q <= cfg_data_i[NumLinksW-1:0];
        REG_LEN0:   len_q[0]    <= cfg_data_i[LenW-1:0];
        REG_LEN1:   len_q[1]    <= cfg_data_i[LenW-1:0];
        REG_LEN2:   len_q[2]    <= cfg_data_i[LenW-1:0];
        REG_LEN3:   len_q[3]    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: advance everything unless the output beat is stuck
  logic [NS:1] v_q;
  logic        adv;
  assign adv        = !v_q[NS] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-1:1], in_valid_i};
    end
  end

  // side data that travels with each beat
  logic [WhichW-1:0] which_q [1:5];
  logic              err_q   [1:NS-1];

  // entry: prefix angle sums and quadrant folding
  logic [InAngW-1:0]     ang_in [Carried];
  logic [ANGLE_BITS-1:0] phi    [MAX_LINKS];
  logic [NW-1:0]         n_eff;
  logic                  err_d;
  logic [30:0]           z_d    [NL];
  logic                  neg_d  [NL];

  assign ang_in[0] = angle_joint0_i;
  assign ang_in[1] = angle_joint1_i;
  assign ang_in[2] = angle_joint2_i;
  assign ang_in[3] = angle_joint3_i;

  always_comb begin
    logic [ANGLE_BITS-1:0] acc;
    logic [ANGLE_BITS-1:0] a;
    logic [31:0]           wide;
    logic [31:0]           t;
    acc  = '0;
    wide = '0;
    for (int k = 0; k < MAX_LINKS; k++) begin
      a = '0;
      if (k < Carried) begin
        wide = {16'b0, ang_in[k]};
        a    = wide[ANGLE_BITS-1:0];
      end
      acc    = acc + a;
      phi[k] = acc;
    end
    for (int l = 0; l < NL; l++) begin
      t = 32'(phi[l/2]) << (32 - ANGLE_BITS);
      if ((l % 2) == 0) t = t + 32'h4000_0000;
      z_d[l]   = t[30] ? (Q30One - {1'b0, t[29:0]}) : {1'b0, t[29:0]};
      neg_d[l] = t[31];
    end
    n_eff = (int'(num_links_q) > MAX_LINKS) ? NW'(MAX_LINKS) : NW'(num_links_q);
    err_d = int'(which_joint_i) > int'(n_eff);
  end

  // trig lanes
  logic [30:0] z1_q  [NL];
  logic        sg_q  [1:5][NL];
  logic [30:0] z2_z_q[NL];
  logic [30:0] z2_q  [NL];
  logic [30:0] z3_z_q[NL];
  logic [30:0] z3_q  [NL];
  logic [29:0] r1_q  [NL];
  logic [30:0] z4_z_q[NL];
  logic [30:0] r2_q  [NL];
  logic [17:0] m_q   [NL];
  logic signed [19:0] term_q [NL];

  always_ff @(posedge clk_i) begin
    logic [61:0] p_zz;
    logic [57:0] p_c;
    logic [60:0] p_r1;
    logic [61:0] p_s;
    logic [32:0] s_rnd;
    logic [34:0] p_len;
    logic [LenW-1:0] ln;
    logic [18:0] mag;
    if (adv) begin
      which_q[1] <= which_joint_i;
      err_q[1]   <= err_d;
      for (int i = 2; i <= 5; i++) which_q[i] <= which_q[i-1];
      for (int i = 2; i < NS; i++) err_q[i] <= err_q[i-1];
      for (int l = 0; l < NL; l++) begin
        // stage 1: folded quarter-wave argument
        z1_q[l]    <= z_d[l];
        sg_q[1][l] <= neg_d[l];
        for (int i = 2; i <= 5; i++) sg_q[i][l] <= sg_q[i-1][l];
        // stage 2: z squared
        p_zz       = 62'(z1_q[l]) * 62'(z1_q[l]);
        z2_q[l]    <= p_zz[60:30];
        z2_z_q[l]  <= z1_q[l];
        // stage 3: B - z2*C
        p_c        = 58'(z2_q[l]) * 58'(TrigC);
        r1_q[l]    <= TrigB - p_c[59-2:30];
        z3_q[l]    <= z2_q[l];
        z3_z_q[l]  <= z2_z_q[l];
        // stage 4: A - z2*r1
        p_r1       = 61'(z3_q[l]) * 61'(r1_q[l]);
        r2_q[l]    <= TrigA - p_r1[60:30];
        z4_z_q[l]  <= z3_z_q[l];
        // stage 5: z*r2, round to Q16
        p_s        = 62'(z4_z_q[l]) * 62'(r2_q[l]);
        s_rnd      = {1'b0, p_s[61:30]} + 33'd8192;
        m_q[l]     <= s_rnd[31:14];
        // stage 6: scale by link length, drop links past the wanted joint
        ln         = ((l / 2) < Carried) ? len_q[(l / 2) % Carried] : '0;
        p_len      = 35'(ln) * 35'(m_q[l]) + 35'd32768;
        mag        = p_len[34:16];
        if ((l / 2) >= int'(which_q[5])) term_q[l] <= '0;
        else term_q[l] <= sg_q[5][l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

  // stage 7: exact sums; stage 8: saturate and flag
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic signed [SUM_W-1:0] sx_d, sy_d;
  logic signed [PosW-1:0]  px_d, py_d;
  localparam logic signed [SUM_W-1:0] PosMax = SUM_W'((1 << (PosW - 1)) - 1);
  localparam logic signed [SUM_W-1:0] PosMin = -SUM_W'(1 << (PosW - 1));

  always_comb begin
    sx_d = SUM_W'(base_x_q);
    sy_d = SUM_W'(base_y_q);
    for (int k = 0; k < MAX_LINKS; k++) begin
      sx_d = sx_d + SUM_W'(term_q[2*k]);
      sy_d = sy_d + SUM_W'(term_q[2*k+1]);
    end
    if (sx_q > PosMax)      px_d = PosMax[PosW-1:0];
    else if (sx_q < PosMin) px_d = PosMin[PosW-1:0];
    else                    px_d = sx_q[PosW-1:0];
    if (sy_q > PosMax)      py_d = PosMax[PosW-1:0];
    else if (sy_q < PosMin) py_d = PosMin[PosW-1:0];
    else                    py_d = sy_q[PosW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q          <= sx_d;
      sy_q          <= sy_d;
      pos_x_o       <= err_q[NS-1] ? '0 : px_d;
      pos_y_o       <= err_q[NS-1] ? '0 : py_d;
      index_error_o <= err_q[NS-1];
    end
  end

  assign out_valid_o = v_q[NS];

  `PAFK_ASSERT(a_err_zero, out_valid_o && index_error_o |-> pos_x_o == '0 && pos_y_o == '0)
  `PAFK_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o)
  `PAFK_ASSERT(a_stall_hold, !in_ready_o |=> $stable(v_q))
endmodule
`default_nettype wire

[verif/pafk_checker.sv]
// Scoreboard for the planar arm forward kinematics unit: follows register writes,
// predicts the joint position of every accepted query and compares the result beats.
// Depends on pafk_pkg.
module pafk_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pafk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pafk_pkg::PosW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [15:0]                   angle_joint0_i,
  input  logic [15:0]                   angle_joint1_i,
  input  logic [15:0]                   angle_joint2_i,
  input  logic [15:0]                   angle_joint3_i,
  input  logic [2:0]                    which_joint_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [23:0]                   pos_x_i,
  input  logic [23:0]                   pos_y_i,
  input  logic                          index_error_i,
  output int                            fails_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pafk_pkg::*;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic        err;
  } pose_t;

  logic signed [23:0] base_x, base_y;
  logic [2:0]         links;
  logic [15:0]        len [4];
  pose_t              poses_due [$];

  function automatic longint quarter_wave(longint unsigned z);
    longint unsigned z2, r, s;
    z2 = (z * z) >> 30;
    r  = longint'(TrigC);
    r  = longint'(TrigB) - ((z2 * r) >> 30);
    r  = longint'(TrigA) - ((z2 * r) >> 30);
    s  = (z * r) >> 30;
    return longint'((s + 64'd8192) >> 14);
  endfunction

  function automatic longint sine_q16(logic [31:0] t);
    longint m;
    if (t[30]) m = quarter_wave(longint'(Q30One) - longint'(t[29:0]));
    else m = quarter_wave(longint'(t[29:0]));
    return t[31] ? -m : m;
  endfunction

  // scale by link length, rounding half away from zero
  function automatic longint scaled(logic [15:0] l, longint trig);
    longint mag, v;
    mag = trig < 0 ? -trig : trig;
    v   = (longint'(l) * mag + 32768) >>> 16;
    return trig < 0 ? -v : v;
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic pose_t joint_pose(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                       logic [15:0] a3, logic [2:0] which);
    logic [15:0] ang [4];
    logic [15:0] phi;
    logic [2:0]  n;
    longint      x, y;
    pose_t       p;
    ang = '{a0, a1, a2, a3};
    n   = links > 3'd4 ? 3'd4 : links;
    p   = '0;
    if (which > n) begin
      p.err = 1'b1;
      return p;
    end
    x   = base_x;
    y   = base_y;
    phi = '0;
    for (int k = 0; k < which; k++) begin
      phi = phi + ang[k];
      x += scaled(len[k], sine_q16({phi, 16'h0} + 32'h4000_0000));
      y += scaled(len[k], sine_q16({phi, 16'h0}));
    end
    p.x = clamp24(x);
    p.y = clamp24(y);
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pose_t want, got;
    if (!rst_ni) begin
      base_x    <= '0;
      base_y    <= '0;
      links     <= NumReset;
      len       <= '{LenReset, LenReset, LenReset, LenReset};
      fails_o   <= 0;
      pending_o <= 0;
      poses_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_BASE_X: base_x <= cfg_data_i;
          REG_BASE_Y: base_y <= cfg_data_i;
          REG_NUM:    links  <= cfg_data_i[2:0];
          REG_LEN0:   len[0] <= cfg_data_i[15:0];
          REG_LEN1:   len[1] <= cfg_data_i[15:0];
          REG_LEN2:   len[2] <= cfg_data_i[15:0];
          REG_LEN3:   len[3] <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        poses_due.insert(poses_due.size(),
                         joint_pose(angle_joint0_i, angle_joint1_i, angle_joint2_i,
                                    angle_joint3_i, which_joint_i));
      if (out_valid_i && out_ready_i) begin
        got = '{pos_x_i, pos_y_i, index_error_i};
        if (poses_due.size() == 0) begin
          if (fails_o < 10) $display("unexpected result beat x=%h y=%h err=%b",
                                     got.x, got.y, got.err);
          fails_o <= fails_o + 1;
        end else begin
          want = poses_due.pop_front();
          if (want != got) begin
            if (fails_o < 10)
              $display("pose mismatch: want x=%h y=%h err=%b, got x=%h y=%h err=%b",
                       want.x, want.y, want.err, got.x, got.y, got.err);
            fails_o <= fails_o + 1;
          end
        end
      end
      pending_o <= poses_due.size();
    end
  end
endmodule

[verif/tb.sv]
// Top of the forward kinematics testbench: clock, reset, stimulus and verdict.
// Depends on pafk_pkg, the unit and pafk_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pafk_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [15:0] angle_joint0_i, angle_joint1_i, angle_joint2_i, angle_joint3_i;
  logic [2:0]  which_joint_i;
  logic        out_valid_o, out_ready_i;
  logic [23:0] pos_x_o, pos_y_o;
  logic        index_error_o;
  int          fails, pending;
  int          send_idle, take_idle;
  bit          hold_off;
  int          links_now;
  int          cycles;

  always #5 clk_i = ~clk_i;

  planar_arm_forward_kinematics_unit u_dut (.*);

  pafk_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .angle_joint0_i, .angle_joint1_i,
    .angle_joint2_i, .angle_joint3_i, .which_joint_i, .out_valid_i(out_valid_o),
    .out_ready_i, .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .index_error_i(index_error_o),
    .fails_o(fails), .pending_o(pending)
  );

  // watchdog: far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold-off when asked
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= take_idle);
        @(posedge clk_i);
      end
    end
  end

  // offer one query beat; valid stays up across back-to-back beats
  task automatic send_query(logic [15:0] a0, a1, a2, a3, logic [2:0] which);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i     <= 1'b1;
    angle_joint0_i <= a0;
    angle_joint1_i <= a1;
    angle_joint2_i <= a2;
    angle_joint3_i <= a3;
    which_joint_i  <= which;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_queries(int count);
    logic [2:0] which;
    for (int i = 0; i < count; i++) begin
      // mostly legal joints of the current arm, some past the end
      if ($urandom_range(99) < 20) which = 3'($urandom_range(7));
      else which = 3'($urandom_range(links_now));
      send_query(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), which);
    end
  endtask

  // drain the pipeline before touching registers, then settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_arm(logic [23:0] bx, by, logic [2:0] n, logic [15:0] l0, l1, l2, l3);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_NUM, {21'h0, n});
    write_reg(REG_LEN0, {8'h0, l0});
    write_reg(REG_LEN1, {8'h0, l1});
    write_reg(REG_LEN2, {8'h0, l2});
    write_reg(REG_LEN3, {8'h0, l3});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    links_now = n > 4 ? 4 : n;
  endtask

  initial begin
    logic [15:0] corners [6];
    corners     = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000};
    cycles      = 0;
    hold_off    = 1'b0;
    send_idle   = 21;
    take_idle   = 54;
    links_now   = 2;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    angle_joint0_i <= '0;
    angle_joint1_i <= '0;
    angle_joint2_i <= '0;
    angle_joint3_i <= '0;
    which_joint_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed sweep at reset registers: quadrant corners, every joint index
    for (int i = 0; i < 18; i++)
      send_query(corners[i % 6], corners[(i + 1) % 6], corners[(i + 3) % 6],
                 corners[(i + 5) % 6], i[2:0]);
    drain();

    // long links from the far corner: saturate, first idle mix
    set_arm(24'h7FFFFF, 24'h7FFFFF, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle = 21;
    take_idle = 54;
    for (int i = 0; i < 8; i++) send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, i[2:0]);
    random_queries(250);
    drain();

    // negative extreme, zero lengths, link count above the maximum, dead register
    set_arm(24'h800000, 24'h800000, 3'd7, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_valid_i <= 1'b0;
    send_idle = 54;
    take_idle = 21;
    for (int i = 0; i < 8; i++) send_query(16'h8000, 16'h8000, 16'h8000, 16'h8000, i[2:0]);
    random_queries(250);
    drain();

    // only the base is valid
    set_arm(24'($urandom), 24'($urandom), 3'd0, 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
    send_idle = 0;
    take_idle = 0;
    random_queries(40);
    drain();

    // single link, then random arm with a receiver hold-off to fill the pipe
    set_arm(24'($urandom), 24'($urandom), 3'd1, 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
    random_queries(60);
    drain();
    set_arm(24'($urandom), 24'($urandom), 3'd3, 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
    hold_off = 1'b1;
    random_queries(200);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/pafk_pkg.sv
sv/planar_arm_forward_kinematics_unit.sv
verif/pafk_checker.sv
verif/tb.sv
